// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the key table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define KFSIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define KFSIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/kfsit_pkg.sv =====
// Shared constants and controller/datapath interface types for the key table.
package kfsit_pkg;

  // Default table sizes.
  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned BUCKETS_DEF  = 256;

  // Hash multiplier; only the low bucket bits of the product are used.
  localparam int unsigned HASH_MULT_W = 12;
  localparam logic [HASH_MULT_W-1:0] HASH_MULT = 12'd3163;

  // Fixed payload widths.
  localparam int unsigned KEY_W = 64;
  localparam int unsigned IDX_W = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;     // write the empty marker at the clear pointer
    logic accept;     // take a request, hash it, read the bucket head
    logic head_cap;   // read the entry that the bucket head names
    logic follow;     // read the entry that the chain link names
    logic res_found;  // post a hit result
    logic ins;        // insert the key (or post full) and post the result
    logic link_head;  // the new entry links to the bucket head, not to empty
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clear pointer is at the last bucket
    logic head_live;   // bucket head names a stored entry
    logic hash_match;  // entry read back hashes to the current bucket
    logic key_hit;     // entry read back holds the request key
    logic link_live;   // chain link names a stored entry
    logic out_free;    // result register can take a result this cycle
  } sts_t;

endpackage

// ===== rtl/kfsit_dp.sv =====
// Datapath of the key table: hash, bucket head memory, entry memories, result register.
`include "assert_macros.svh"

module kfsit_dp #(
  parameter int unsigned CAPACITY = kfsit_pkg::CAPACITY_DEF,
  parameter int unsigned BUCKETS  = kfsit_pkg::BUCKETS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [kfsit_pkg::KEY_W-1:0]  key_i,
  input  logic                         start_new_i,
  input  logic                         out_stall_i,
  input  kfsit_pkg::cmd_t              cmd_i,
  output kfsit_pkg::sts_t              sts_o,
  output logic                         out_valid_o,
  output logic                         found_o,
  output logic [kfsit_pkg::IDX_W-1:0]  entry_index_o,
  output logic                         full_res_o
);
  import kfsit_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);      // entry address width
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count and link width
  localparam int unsigned BW = $clog2(BUCKETS);       // bucket address width
  localparam logic [CW-1:0] EMPTY_MARK = {CW{1'b1}};

  // Bucket of a key: low bits of key times the multiplier, masked to the bucket count.
  function automatic logic [BW-1:0] bucket_of(input logic [KEY_W-1:0] k);
    logic [BW+HASH_MULT_W-1:0] prod;
    begin
      prod = (BW + HASH_MULT_W)'(k[BW-1:0]) * (BW + HASH_MULT_W)'(HASH_MULT);
      return prod[BW-1:0] & BW'(BUCKETS - 1);
    end
  endfunction

  // Low result bits of an index.
  function automatic logic [IDX_W-1:0] to_idx(input logic [CW-1:0] v);
    logic [CW+IDX_W-1:0] w;
    begin
      w = (CW + IDX_W)'(v);
      return w[IDX_W-1:0];
    end
  endfunction

  logic [KEY_W-1:0] key_q;
  logic [BW-1:0]    bucket_q;
  logic [CW-1:0]    count_q;
  logic [BW-1:0]    clr_q;
  logic [IW-1:0]    cur_q;
  logic [CW-1:0]    head_rd_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [CW-1:0]    link_rd_q;
  logic             out_valid_q;
  logic             found_q;
  logic [IDX_W-1:0] idx_q;
  logic             full_q;

  logic [CW-1:0]    head_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [CAPACITY];
  logic [CW-1:0]    link_mem [CAPACITY];

  logic             full;
  logic             ins_do;
  logic             hd_we;
  logic [BW-1:0]    hd_wa;
  logic [CW-1:0]    hd_wd;
  logic             ent_re;
  logic [IW-1:0]    ent_ra;
  logic [CW-1:0]    link_wd;

  assign full    = (count_q == CW'(CAPACITY));
  assign ins_do  = cmd_i.ins && !full;
  assign hd_we   = cmd_i.clr_we || ins_do;
  assign hd_wa   = cmd_i.clr_we ? clr_q : bucket_q;
  assign hd_wd   = cmd_i.clr_we ? EMPTY_MARK : count_q;
  assign ent_re  = cmd_i.head_cap || cmd_i.follow;
  assign ent_ra  = cmd_i.head_cap ? head_rd_q[IW-1:0] : link_rd_q[IW-1:0];
  assign link_wd = cmd_i.link_head ? head_rd_q : EMPTY_MARK;

  // Bucket head memory: cleared entry by entry after reset, read at request time.
  always_ff @(posedge clk_i) begin
    if (hd_we) begin
      head_mem[hd_wa] <= hd_wd;
    end
    if (cmd_i.accept) begin
      head_rd_q <= head_mem[bucket_of(key_i)];
    end
  end

  // Entry memories: stored keys and chain links, one read per chain visit.
  always_ff @(posedge clk_i) begin
    if (ins_do) begin
      key_mem[count_q[IW-1:0]]  <= key_q;
      link_mem[count_q[IW-1:0]] <= link_wd;
    end
    if (ent_re) begin
      key_rd_q  <= key_mem[ent_ra];
      link_rd_q <= link_mem[ent_ra];
      cur_q     <= ent_ra;
    end
  end

  // Request key and its bucket.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q    <= key_i;
      bucket_q <= bucket_of(key_i);
    end
  end

  // Entry count and clear pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.accept && start_new_i) begin
        count_q <= '0;
      end else if (ins_do) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.clr_we) begin
        clr_q <= clr_q + BW'(1);
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_found || cmd_i.ins) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_found) begin
      found_q <= 1'b1;
      idx_q   <= to_idx(CW'(cur_q));
      full_q  <= 1'b0;
    end else if (cmd_i.ins) begin
      found_q <= 1'b0;
      idx_q   <= full ? '0 : to_idx(count_q);
      full_q  <= full;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.clr_last   = (clr_q == BW'(BUCKETS - 1));
    sts_o.head_live  = (head_rd_q < count_q);
    sts_o.hash_match = (bucket_of(key_rd_q) == bucket_q);
    sts_o.key_hit    = (key_rd_q == key_q);
    sts_o.link_live  = (link_rd_q < count_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign entry_index_o = idx_q;
  assign full_res_o    = full_q;

  `KFSIT_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `KFSIT_ASSERT(a_hit_index_live, cmd_i.res_found |-> (CW'(cur_q) < count_q), "hit on dead entry")
  `KFSIT_ASSERT(a_insert_counts, ins_do && !(cmd_i.accept && start_new_i) |=> count_q == $past(count_q) + CW'(1), "insert did not advance count")

endmodule

// ===== rtl/kfsit_ctrl.sv =====
// Controller of the key table: bucket clearing sweep and chain walk sequencing.
`include "assert_macros.svh"

module kfsit_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kfsit_pkg::sts_t sts_i,
  output kfsit_pkg::cmd_t cmd_o
);
  import kfsit_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;  // sweep empty markers into the bucket heads
  localparam logic [2:0] S_IDLE = 3'd1;  // wait for a request
  localparam logic [2:0] S_HEAD = 3'd2;  // bucket head read back
  localparam logic [2:0] S_CMPF = 3'd3;  // first chain entry read back
  localparam logic [2:0] S_CMP  = 3'd4;  // later chain entry read back
  localparam logic [2:0] S_INS  = 3'd5;  // insert or report full

  logic [2:0] state_q, state_d;
  logic       hok_q, hok_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    hok_d   = hok_q;
    cmd_o   = '0;
    cmd_o.link_head = hok_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_HEAD;
        end
      end
      S_HEAD: begin
        if (sts_i.head_live) begin
          cmd_o.head_cap = 1'b1;
          state_d        = S_CMPF;
        end else begin
          hok_d   = 1'b0;
          state_d = S_INS;
        end
      end
      S_CMPF: begin
        // A head left over from before a table restart can belong to another bucket.
        if (!sts_i.hash_match) begin
          hok_d   = 1'b0;
          state_d = S_INS;
        end else if (sts_i.key_hit) begin
          if (sts_i.out_free) begin
            cmd_o.res_found = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (sts_i.link_live) begin
          cmd_o.follow = 1'b1;
          hok_d        = 1'b1;
          state_d      = S_CMP;
        end else begin
          hok_d   = 1'b1;
          state_d = S_INS;
        end
      end
      S_CMP: begin
        if (sts_i.key_hit) begin
          if (sts_i.out_free) begin
            cmd_o.res_found = 1'b1;
            state_d         = S_IDLE;
          end
        end else if (sts_i.link_live) begin
          cmd_o.follow = 1'b1;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.ins = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      hok_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hok_q   <= hok_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  `KFSIT_ASSERT(a_result_slot_free, (cmd_o.res_found || cmd_o.ins) |-> sts_i.out_free, "result posted over a waiting result")
  `KFSIT_ASSERT(a_accept_leads_head, cmd_o.accept |=> (state_q == S_HEAD && in_stall_o), "accepted request did not start a lookup")

endmodule

// ===== rtl/key_to_first_seen_index_table.sv =====
// Top level of the key table: numbers distinct 64-bit keys in first-seen order.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | key_i, start_new_i
//   out     | output    | out_valid_o / out_stall_i| found_o, entry_index_o, full_res_o
//
// A request ends in a hit at a chain entry, or in a miss after all chain entries (the
// chain may be empty); each chain entry is one read of the entry memories, which sets
// the rate. One request is in work at a time.
// After reset the block runs a clearing pass over every entry of the bucket head
// memory with in_stall_o high. start_new empties the table without a sweep.
// A stalled result holds the walk at its last step; a new request is taken while
// the previous result still waits.
module key_to_first_seen_index_table #(
  parameter int unsigned CAPACITY = kfsit_pkg::CAPACITY_DEF,
  parameter int unsigned BUCKETS  = kfsit_pkg::BUCKETS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kfsit_pkg::KEY_W-1:0]  key_i,
  input  logic                         start_new_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [kfsit_pkg::IDX_W-1:0]  entry_index_o,
  output logic                         full_res_o
);
  import kfsit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  kfsit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Memories and result register.
  kfsit_dp #(
    .CAPACITY (CAPACITY),
    .BUCKETS  (BUCKETS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_i         (key_i),
    .start_new_i   (start_new_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .found_o       (found_o),
    .entry_index_o (entry_index_o),
    .full_res_o    (full_res_o)
  );

endmodule
